// ----- hdl/rcw_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rcw_pkg
// Shared types and constants for the rectangle clip and window command block.
// ----------------------------------------------------------------------------
package rcw_pkg;

   localparam int COORD_IN_WIDTH  = 16;
   localparam int LIMIT_WIDTH     = 11;
   localparam int SIZE_WIDTH      = 12;
   localparam int OFFSET_WIDTH    = 8;
   localparam int WIDE_WIDTH      = 18;
   localparam int COLOR_WIDTH     = 16;
   localparam int FIRST_WIDTH     = 16;
   localparam int SECOND_WIDTH    = 23;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 11;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);

   localparam logic [LIMIT_WIDTH-1:0]  RESET_LAST_COLUMN   = 11'd479;
   localparam logic [LIMIT_WIDTH-1:0]  RESET_LAST_ROW      = 11'd479;
   localparam logic [OFFSET_WIDTH-1:0] RESET_COLUMN_OFFSET = 8'd0;
   localparam logic [OFFSET_WIDTH-1:0] RESET_ROW_OFFSET    = 8'd0;

   typedef enum logic [1:0] {
      CMD_COLUMN_SET = 2'd0,
      CMD_ROW_SET    = 2'd1,
      CMD_MEM_WRITE  = 2'd2,
      CMD_REPEAT     = 2'd3
   } cmd_kind_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_LAST_COLUMN   = 4'd0,
      REG_LAST_ROW      = 4'd1,
      REG_COLUMN_OFFSET = 4'd2,
      REG_ROW_OFFSET    = 4'd3
   } reg_index_type;

   typedef struct packed {
      logic [LIMIT_WIDTH-1:0]  last_column;
      logic [LIMIT_WIDTH-1:0]  last_row;
      logic [OFFSET_WIDTH-1:0] column_offset;
      logic [OFFSET_WIDTH-1:0] row_offset;
   } cfg_type;

   typedef struct packed {
      logic                   visible;
      logic [LIMIT_WIDTH-1:0] start;
      logic [SIZE_WIDTH-1:0]  size;
   } axis_type;

   // One clipped rectangle as it travels from the front to the back.
   typedef struct packed {
      logic                   new_window;
      logic [LIMIT_WIDTH-1:0] x;
      logic [SIZE_WIDTH-1:0]  w;
      logic [LIMIT_WIDTH-1:0] y;
      logic [SIZE_WIDTH-1:0]  h;
      logic [COLOR_WIDTH-1:0] color;
   } window_type;

   typedef struct packed {
      logic       valid;
      window_type entry;
   } queue_push_type;

endpackage : rcw_pkg
`default_nettype wire

// ----- hdl/rcw_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rcw_front
// Accepts requests, flips and clips both axes, checks the window cache and
// pushes visible rectangles into the command queue.
// ----------------------------------------------------------------------------
module rcw_front (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire rcw_pkg::cfg_type                      cfg,
   input  wire logic                                  cache_flush,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [rcw_pkg::COORD_IN_WIDTH-1:0] req_rect_x,
   input  wire logic signed [rcw_pkg::COORD_IN_WIDTH-1:0] req_rect_y,
   input  wire logic signed [rcw_pkg::COORD_IN_WIDTH-1:0] req_rect_w,
   input  wire logic signed [rcw_pkg::COORD_IN_WIDTH-1:0] req_rect_h,
   input  wire logic [rcw_pkg::COLOR_WIDTH-1:0]       req_fill_color,
   input  wire logic                                  queue_full,
   output rcw_pkg::queue_push_type                    push
);

   function automatic rcw_pkg::axis_type clip_axis(
      input logic signed [rcw_pkg::COORD_IN_WIDTH-1:0] pos,
      input logic signed [rcw_pkg::COORD_IN_WIDTH-1:0] len,
      input logic [rcw_pkg::LIMIT_WIDTH-1:0]           limit
   );
      logic signed [rcw_pkg::WIDE_WIDTH-1:0] pos_w;
      logic signed [rcw_pkg::WIDE_WIDTH-1:0] len_w;
      logic signed [rcw_pkg::WIDE_WIDTH-1:0] lim_w;
      logic signed [rcw_pkg::WIDE_WIDTH-1:0] p;
      logic signed [rcw_pkg::WIDE_WIDTH-1:0] e;
      logic signed [rcw_pkg::WIDE_WIDTH-1:0] cs;
      logic signed [rcw_pkg::WIDE_WIDTH-1:0] ce;
      logic signed [rcw_pkg::WIDE_WIDTH-1:0] n;
      rcw_pkg::axis_type                     r;
      pos_w = rcw_pkg::WIDE_WIDTH'(pos);
      len_w = rcw_pkg::WIDE_WIDTH'(len);
      lim_w = signed'({{(rcw_pkg::WIDE_WIDTH-rcw_pkg::LIMIT_WIDTH){1'b0}}, limit});
      // a negative size spans back toward the origin and ends at pos
      if (len_w < 0) begin
         p = pos_w + len_w + 1;
         e = pos_w;
      end else begin
         p = pos_w;
         e = pos_w + len_w - 1;
      end
      cs = (p < 0) ? '0 : p;
      ce = (e > lim_w) ? lim_w : e;
      n  = ce - cs + 1;
      r.visible = (len_w != 0) && (p <= lim_w) && (e >= 0);
      r.start   = cs[rcw_pkg::LIMIT_WIDTH-1:0];
      r.size    = n[rcw_pkg::SIZE_WIDTH-1:0];
      return r;
   endfunction

   rcw_pkg::axis_type clip_x;
   rcw_pkg::axis_type clip_y;

   logic                                s1_valid_ff, s1_valid_in;
   logic [rcw_pkg::LIMIT_WIDTH-1:0]     s1_x_ff, s1_y_ff;
   logic [rcw_pkg::SIZE_WIDTH-1:0]      s1_w_ff, s1_h_ff;
   logic [rcw_pkg::COLOR_WIDTH-1:0]     s1_color_ff;
   logic                                accept;

   logic                                cache_valid_ff, cache_valid_in;
   logic [rcw_pkg::LIMIT_WIDTH-1:0]     cache_x_ff, cache_y_ff;
   logic [rcw_pkg::SIZE_WIDTH-1:0]      cache_w_ff, cache_h_ff;
   logic                                cache_hit;

   always_comb begin
      clip_x      = clip_axis(req_rect_x, req_rect_w, cfg.last_column);
      clip_y      = clip_axis(req_rect_y, req_rect_h, cfg.last_row);
      req_stall   = s1_valid_ff && queue_full;
      accept      = req_valid && !req_stall;
      // hold while stalled, drop rectangles with nothing on screen
      s1_valid_in = req_stall ? s1_valid_ff : (accept && clip_x.visible && clip_y.visible);

      cache_hit = cache_valid_ff && (cache_x_ff == s1_x_ff) && (cache_w_ff == s1_w_ff)
                  && (cache_y_ff == s1_y_ff) && (cache_h_ff == s1_h_ff);

      push.valid            = s1_valid_ff && !queue_full;
      push.entry.new_window = !cache_hit;
      push.entry.x          = s1_x_ff;
      push.entry.w          = s1_w_ff;
      push.entry.y          = s1_y_ff;
      push.entry.h          = s1_h_ff;
      push.entry.color      = s1_color_ff;

      cache_valid_in = cache_valid_ff;
      if (cache_flush) begin
         cache_valid_in = 1'b0;
      end else if (push.valid) begin
         cache_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         cache_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         cache_valid_ff <= cache_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_x_ff     <= clip_x.start;
         s1_w_ff     <= clip_x.size;
         s1_y_ff     <= clip_y.start;
         s1_h_ff     <= clip_y.size;
         s1_color_ff <= req_fill_color;
      end
      if (push.valid) begin
         cache_x_ff <= s1_x_ff;
         cache_w_ff <= s1_w_ff;
         cache_y_ff <= s1_y_ff;
         cache_h_ff <= s1_h_ff;
      end
   end

endmodule : rcw_front
`default_nettype wire

// ----- hdl/rcw_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rcw_queue
// Short queue of clipped rectangles between the front and the back.
// ----------------------------------------------------------------------------
module rcw_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire rcw_pkg::queue_push_type push,
   output logic                         full,
   output logic                         head_valid,
   output rcw_pkg::window_type          head,
   input  wire logic                    pop
);

   rcw_pkg::window_type                   entries_ff [rcw_pkg::QUEUE_DEPTH];
   logic [rcw_pkg::QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [rcw_pkg::QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [rcw_pkg::QUEUE_PTR_WIDTH:0]     count_ff, count_in;
   logic                                  do_push, do_pop;

   always_comb begin
      full       = (count_ff == (rcw_pkg::QUEUE_PTR_WIDTH+1)'(rcw_pkg::QUEUE_DEPTH));
      head_valid = (count_ff != '0);
      head       = entries_ff[rd_ptr_ff];
      do_push    = push.valid && !full;
      do_pop     = pop && head_valid;
      wr_ptr_in  = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule : rcw_queue
`default_nettype wire

// ----- hdl/rcw_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rcw_back
// Walks each queued rectangle through its panel commands, one per cycle unless
// a full result register is stalled, into the result register.
// ----------------------------------------------------------------------------
module rcw_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire rcw_pkg::cfg_type                  cfg,
   input  wire logic                              head_valid,
   input  wire rcw_pkg::window_type               head,
   output logic                                   pop,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [1:0]                             rsp_cmd_kind,
   output logic [rcw_pkg::FIRST_WIDTH-1:0]        rsp_first_value,
   output logic [rcw_pkg::SECOND_WIDTH-1:0]       rsp_second_value,
   output logic                                   rsp_last_of_run
);

   rcw_pkg::cmd_kind_type                 step_ff, step_in;
   rcw_pkg::cmd_kind_type                 cur_kind;
   logic                                  load;

   logic                                  rsp_valid_ff, rsp_valid_in;
   rcw_pkg::cmd_kind_type                 kind_ff, kind_in;
   logic [rcw_pkg::FIRST_WIDTH-1:0]       first_ff, first_in;
   logic [rcw_pkg::SECOND_WIDTH-1:0]      second_ff, second_in;
   logic                                  last_ff, last_in;

   logic [rcw_pkg::SIZE_WIDTH-1:0]        col_start, col_end;
   logic [rcw_pkg::SIZE_WIDTH-1:0]        row_start, row_end;
   logic [2*rcw_pkg::SIZE_WIDTH-1:0]      pixels;

   always_comb begin
      col_start = rcw_pkg::SIZE_WIDTH'(head.x) + rcw_pkg::SIZE_WIDTH'(cfg.column_offset);
      col_end   = col_start + head.w - 1'b1;
      row_start = rcw_pkg::SIZE_WIDTH'(head.y) + rcw_pkg::SIZE_WIDTH'(cfg.row_offset);
      row_end   = row_start + head.h - 1'b1;
      pixels    = head.w * head.h;

      // skip the two set commands when the window is already loaded
      cur_kind = step_ff;
      if (step_ff == rcw_pkg::CMD_COLUMN_SET && !head.new_window) begin
         cur_kind = rcw_pkg::CMD_MEM_WRITE;
      end

      load = head_valid && (!rsp_valid_ff || !rsp_stall);
      pop  = load && (cur_kind == rcw_pkg::CMD_REPEAT);

      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      last_in      = last_ff;

      if (load) begin
         rsp_valid_in = 1'b1;
         kind_in      = cur_kind;
         last_in      = 1'b0;
         case (cur_kind)
            rcw_pkg::CMD_COLUMN_SET: begin
               first_in  = rcw_pkg::FIRST_WIDTH'(col_start);
               second_in = rcw_pkg::SECOND_WIDTH'(col_end);
               step_in   = rcw_pkg::CMD_ROW_SET;
            end
            rcw_pkg::CMD_ROW_SET: begin
               first_in  = rcw_pkg::FIRST_WIDTH'(row_start);
               second_in = rcw_pkg::SECOND_WIDTH'(row_end);
               step_in   = rcw_pkg::CMD_MEM_WRITE;
            end
            rcw_pkg::CMD_MEM_WRITE: begin
               first_in  = '0;
               second_in = '0;
               step_in   = rcw_pkg::CMD_REPEAT;
            end
            rcw_pkg::CMD_REPEAT: begin
               first_in  = head.color;
               second_in = pixels[rcw_pkg::SECOND_WIDTH-1:0];
               last_in   = 1'b1;
               step_in   = rcw_pkg::CMD_COLUMN_SET;
            end
            default: begin
               step_in = rcw_pkg::CMD_COLUMN_SET;
            end
         endcase
      end

      rsp_valid        = rsp_valid_ff;
      rsp_cmd_kind     = kind_ff;
      rsp_first_value  = first_ff;
      rsp_second_value = second_ff;
      rsp_last_of_run  = last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= rcw_pkg::CMD_COLUMN_SET;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      first_ff  <= first_in;
      second_ff <= second_in;
      last_ff   <= last_in;
   end

endmodule : rcw_back
`default_nettype wire

// ----- hdl/rect_clip_window_command_gen.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rect_clip_window_command_gen
// Fill-rectangle request to panel command stream, with clipping and a cache
// of the last address window.
// ----------------------------------------------------------------------------
// The result channel carries one command per cycle unless rsp_stall holds it.
// A rectangle whose clipped window differs from the cached one produces four
// commands (column set, row set, memory write start, repeat), one that hits
// the cache produces two, and an empty or off-screen rectangle produces none
// and is dropped in the front stage. The front takes one request per cycle
// unless the four-entry queue is full, so it keeps accepting while the back
// stage works off earlier rectangles and a finished command waits in the
// output register; the back stage's command sequencer sets the sustained rate.
// A request is registered in the front, then in the queue, then in the output
// register, where its first command appears. The configuration port is always
// ready; every write, to any index, drops the cached window.
// ----------------------------------------------------------------------------
module rect_clip_window_command_gen (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_valid,
   output logic                                           req_stall,
   input  wire logic signed [rcw_pkg::COORD_IN_WIDTH-1:0] req_rect_x,
   input  wire logic signed [rcw_pkg::COORD_IN_WIDTH-1:0] req_rect_y,
   input  wire logic signed [rcw_pkg::COORD_IN_WIDTH-1:0] req_rect_w,
   input  wire logic signed [rcw_pkg::COORD_IN_WIDTH-1:0] req_rect_h,
   input  wire logic [rcw_pkg::COLOR_WIDTH-1:0]           req_fill_color,
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_stall,
   output logic [1:0]                                     rsp_cmd_kind,
   output logic [rcw_pkg::FIRST_WIDTH-1:0]                rsp_first_value,
   output logic [rcw_pkg::SECOND_WIDTH-1:0]               rsp_second_value,
   output logic                                           rsp_last_of_run,
   input  wire logic                                      csr_valid,
   output logic                                           csr_ready,
   input  wire logic [rcw_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  wire logic [rcw_pkg::CSR_DATA_WIDTH-1:0]        csr_wdata
);

   rcw_pkg::cfg_type        cfg_ff, cfg_in;
   logic                    csr_write;
   rcw_pkg::queue_push_type push;
   logic                    queue_full;
   logic                    head_valid;
   rcw_pkg::window_type     head;
   logic                    pop;

   always_comb begin
      csr_ready = 1'b1;
      csr_write = csr_valid && csr_ready;
      cfg_in    = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            rcw_pkg::REG_LAST_COLUMN:   cfg_in.last_column   = csr_wdata;
            rcw_pkg::REG_LAST_ROW:      cfg_in.last_row      = csr_wdata;
            rcw_pkg::REG_COLUMN_OFFSET:
               cfg_in.column_offset = csr_wdata[rcw_pkg::OFFSET_WIDTH-1:0];
            rcw_pkg::REG_ROW_OFFSET:
               cfg_in.row_offset = csr_wdata[rcw_pkg::OFFSET_WIDTH-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.last_column   <= rcw_pkg::RESET_LAST_COLUMN;
         cfg_ff.last_row      <= rcw_pkg::RESET_LAST_ROW;
         cfg_ff.column_offset <= rcw_pkg::RESET_COLUMN_OFFSET;
         cfg_ff.row_offset    <= rcw_pkg::RESET_ROW_OFFSET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rcw_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .cache_flush    (csr_write),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rect_x     (req_rect_x),
      .req_rect_y     (req_rect_y),
      .req_rect_w     (req_rect_w),
      .req_rect_h     (req_rect_h),
      .req_fill_color (req_fill_color),
      .queue_full     (queue_full),
      .push           (push)
   );

   rcw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (queue_full),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   rcw_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .head_valid       (head_valid),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cmd_kind     (rsp_cmd_kind),
      .rsp_first_value  (rsp_first_value),
      .rsp_second_value (rsp_second_value),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   // only the repeat command closes a rectangle's run
   a_last_on_repeat : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_of_run == (rsp_cmd_kind == rcw_pkg::CMD_REPEAT)))
      else $error("last_of_run does not match repeat command");

   // a set command never carries an end address below its start
   a_window_order : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_cmd_kind == rcw_pkg::CMD_COLUMN_SET
                     || rsp_cmd_kind == rcw_pkg::CMD_ROW_SET))
      |-> (rsp_first_value <= rsp_second_value[rcw_pkg::FIRST_WIDTH-1:0]))
      else $error("set command end address below start");

   // a visible rectangle always covers at least one pixel
   a_repeat_nonzero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_cmd_kind == rcw_pkg::CMD_REPEAT) |-> (rsp_second_value != '0))
      else $error("repeat command with zero pixel count");

   // the sequencer only pops an entry that is there
   a_pop_has_head : assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue popped while empty");

endmodule : rect_clip_window_command_gen
`default_nettype wire
